// File: src/ttim_pkg.sv
`default_nettype none
package ttim_pkg;

  // Field and register widths.
  localparam int IdxW      = 48;
  localparam int SizeW     = 13;
  localparam int ElemPortW = 64;
  localparam int Slots     = 4;
  localparam int CntW      = 3;
  localparam int OrdW      = 8;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 13;
  localparam int StrideW   = 3 * SizeW;

  // Divider geometry: quotient bits resolved per pipeline stage.
  localparam int StepsPerStage = 4;
  localparam int StagesPerAxis = IdxW / StepsPerStage;

  typedef logic [Slots-1:0][SizeW-1:0] size_arr_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegAxisCount = 3'd0,
    RegSize0     = 3'd1,
    RegSize1     = 3'd2,
    RegSize2     = 3'd3,
    RegSize3     = 3'd4,
    RegAxisOrder = 3'd5
  } cfg_reg_e;

  // Number of axes in use: zero counts as one, clamped to the slot limit.
  function automatic logic [CntW-1:0] eff_count(input logic [CntW-1:0] cnt,
                                                input logic [CntW-1:0] lim);
    logic [CntW-1:0] n;
    n = cnt;
    if (n == '0) n = CntW'(1);
    if (n > lim) n = lim;
    return n;
  endfunction

endpackage
`default_nettype wire

// File: src/ttim_divider.sv
`default_nettype none
// Pipelined mixed-radix split of a linear index into per-axis coordinates.
module ttim_divider #(
  parameter int NumAxes = 4,
  parameter int ElemW   = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_vld_i,
  input  wire logic [ttim_pkg::IdxW-1:0]     in_idx_i,
  input  wire logic [ElemW-1:0]              in_elem_i,
  input  wire ttim_pkg::size_arr_t           sizes_i,
  input  wire logic [ttim_pkg::CntW-1:0]     count_i,
  output logic                               out_vld_o,
  output ttim_pkg::size_arr_t                out_coord_o,
  output logic                               out_oor_o,
  output logic [ElemW-1:0]                   out_elem_o
);

  localparam int NumStages = NumAxes * ttim_pkg::StagesPerAxis;
  localparam int IdxW      = ttim_pkg::IdxW;
  localparam int SizeW     = ttim_pkg::SizeW;

  typedef struct packed {
    logic [IdxW-1:0]     word;
    logic [SizeW-1:0]    rem;
    ttim_pkg::size_arr_t coord;
    logic                bad;
  } div_item_t;

  logic [NumStages-1:0] vld_q;
  div_item_t            item_q [NumStages];
  logic [ElemW-1:0]     elem_q [NumStages];
  div_item_t            entry;

  // A zero size among the axes in use makes the volume zero.
  always_comb begin
    entry.word  = in_idx_i;
    entry.rem   = '0;
    entry.coord = '0;
    entry.bad   = 1'b0;
    for (int a = 0; a < ttim_pkg::Slots; a++) begin
      if ((ttim_pkg::CntW'(a) < count_i) && (sizes_i[a] == '0)) entry.bad = 1'b1;
    end
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    localparam int Ax   = NumAxes - 1 - s / ttim_pkg::StagesPerAxis;
    localparam bit Last = (s % ttim_pkg::StagesPerAxis) == ttim_pkg::StagesPerAxis - 1;
    div_item_t        cur;
    div_item_t        nxt;
    logic [SizeW-1:0] dv;
    logic [SizeW:0]   r14;
    logic             vin;
    logic [ElemW-1:0] ein;

    if (s == 0) begin : g_first
      assign cur = entry;
      assign vin = in_vld_i;
      assign ein = in_elem_i;
    end else begin : g_next
      assign cur = item_q[s-1];
      assign vin = vld_q[s-1];
      assign ein = elem_q[s-1];
    end

    // Axes beyond the count divide by one and leave a zero coordinate.
    assign dv = (ttim_pkg::CntW'(Ax) < count_i) ? sizes_i[Ax] : SizeW'(1);

    // Four restoring division steps, quotient bits shifted into the word.
    always_comb begin
      nxt = cur;
      r14 = '0;
      for (int k = 0; k < ttim_pkg::StepsPerStage; k++) begin
        r14 = {nxt.rem, nxt.word[IdxW-1]};
        nxt.word = {nxt.word[IdxW-2:0], 1'b0};
        if (r14 >= {1'b0, dv}) begin
          r14 = r14 - {1'b0, dv};
          nxt.word[0] = 1'b1;
        end
        nxt.rem = r14[SizeW-1:0];
      end
      if (Last) begin
        nxt.coord[Ax] = nxt.rem;
        nxt.rem       = '0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      item_q[s] <= nxt;
      elem_q[s] <= ein;
    end
  end

  // A quotient left over after the outermost axis means the index is past the volume.
  assign out_vld_o   = vld_q[NumStages-1];
  assign out_coord_o = item_q[NumStages-1].coord;
  assign out_oor_o   = item_q[NumStages-1].bad || (item_q[NumStages-1].word != '0);
  assign out_elem_o  = elem_q[NumStages-1];

endmodule
`default_nettype wire

// File: src/tensor_transpose_index_map_unit.sv
`default_nettype none
// Transpose index map: each item accepted on start (busy is always low) returns one
// result on result_valid_o, one item per cycle sustained. Each item passes through
// the divider pipeline, which resolves four quotient bits per stage and twelve
// stages per axis, followed by a multiply stage, an adder stage and the output
// register. Results cannot be stalled. Destination strides are recomputed after a
// write through the psz, product, tpre and dstride registers, well before an item
// that follows the write reaches the multiply stage.
module tensor_transpose_index_map_unit #(
  parameter int MAX_AXES     = 4,
  parameter int ELEMENT_BITS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [ttim_pkg::IdxW-1:0]          src_index_i,
  input  wire logic [ttim_pkg::ElemPortW-1:0]     element_i,
  output logic                                    result_valid_o,
  output logic [ttim_pkg::IdxW-1:0]               dst_index_o,
  output logic [ttim_pkg::ElemPortW-1:0]          element_out_o,
  output logic                                    out_of_range_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [ttim_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [ttim_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int NumAxes = (MAX_AXES > ttim_pkg::Slots) ? ttim_pkg::Slots : MAX_AXES;
  localparam int Lat     = NumAxes * ttim_pkg::StagesPerAxis + 3;
  localparam int IdxW    = ttim_pkg::IdxW;
  localparam int SizeW   = ttim_pkg::SizeW;
  localparam int StrideW = ttim_pkg::StrideW;
  localparam int Slots   = ttim_pkg::Slots;

  logic [ttim_pkg::CntW-1:0] count_q;
  ttim_pkg::size_arr_t       size_q;
  logic [ttim_pkg::OrdW-1:0] order_q;
  logic [ttim_pkg::CntW-1:0] n_eff;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= ttim_pkg::CntW'(1);
      for (int a = 0; a < Slots; a++) size_q[a] <= SizeW'(1);
      order_q <= ttim_pkg::OrdW'(228);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ttim_pkg::RegAxisCount: count_q   <= cfg_data_i[ttim_pkg::CntW-1:0];
        ttim_pkg::RegSize0:     size_q[0] <= cfg_data_i[SizeW-1:0];
        ttim_pkg::RegSize1:     size_q[1] <= cfg_data_i[SizeW-1:0];
        ttim_pkg::RegSize2:     size_q[2] <= cfg_data_i[SizeW-1:0];
        ttim_pkg::RegSize3:     size_q[3] <= cfg_data_i[SizeW-1:0];
        ttim_pkg::RegAxisOrder: order_q   <= cfg_data_i[ttim_pkg::OrdW-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = ttim_pkg::eff_count(count_q, ttim_pkg::CntW'(NumAxes));
  assign busy  = 1'b0;

  // Stride pipeline, step one: size of the source axis behind each destination axis.
  logic [Slots-1:0][SizeW-1:0] psz_d, psz_q;
  always_comb begin
    for (int k = 0; k < Slots; k++) begin
      psz_d[k] = SizeW'(1);
      if ((ttim_pkg::CntW'(k) < n_eff) &&
          ({1'b0, order_q[2*k +: 2]} < n_eff)) begin
        psz_d[k] = size_q[order_q[2*k +: 2]];
      end
    end
  end

  // Step two and three: running products from the innermost destination axis.
  logic [2*SizeW-1:0]          m23_q;
  logic [SizeW-1:0]            psz1_q, psz3_q;
  logic [Slots-1:0][StrideW-1:0] tpre_q;
  logic [Slots-1:0][StrideW-1:0] dstride_d, dstride_q;

  always_ff @(posedge clk_i) begin
    psz_q     <= psz_d;
    m23_q     <= psz_q[2] * psz_q[3];
    psz1_q    <= psz_q[1];
    psz3_q    <= psz_q[3];
    tpre_q[0] <= psz1_q * StrideW'(m23_q);
    tpre_q[1] <= StrideW'(m23_q);
    tpre_q[2] <= StrideW'(psz3_q);
    tpre_q[3] <= StrideW'(1);
    dstride_q <= dstride_d;
  end

  // Step four: each source axis takes the stride of the lowest destination naming it.
  always_comb begin
    for (int a = 0; a < Slots; a++) begin
      dstride_d[a] = '0;
      for (int d = Slots - 1; d >= 0; d--) begin
        if ((ttim_pkg::CntW'(d) < n_eff) && (order_q[2*d +: 2] == 2'(a))) begin
          dstride_d[a] = tpre_q[d];
        end
      end
    end
  end

  // Coordinate extraction.
  logic                    div_vld;
  ttim_pkg::size_arr_t     div_coord;
  logic                    div_oor;
  logic [ELEMENT_BITS-1:0] div_elem;

  ttim_divider #(
    .NumAxes (NumAxes),
    .ElemW   (ELEMENT_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (start && !busy),
    .in_idx_i    (src_index_i),
    .in_elem_i   (element_i[ELEMENT_BITS-1:0]),
    .sizes_i     (size_q),
    .count_i     (n_eff),
    .out_vld_o   (div_vld),
    .out_coord_o (div_coord),
    .out_oor_o   (div_oor),
    .out_elem_o  (div_elem)
  );

  // Multiply each coordinate by its destination stride.
  logic                      mul_vld_q, sum_vld_q, res_vld_q;
  logic [Slots-1:0][IdxW-1:0] prod_q;
  logic                      mul_oor_q, sum_oor_q;
  logic [ELEMENT_BITS-1:0]   mul_elem_q, sum_elem_q;
  logic [IdxW-1:0]           s01_q, s23_q, dst_q;
  logic [ELEMENT_BITS-1:0]   res_elem_q;
  logic                      res_oor_q;
  logic [SizeW+StrideW-1:0]  prod_full [Slots];

  always_comb begin
    for (int a = 0; a < Slots; a++) begin
      prod_full[a] = (SizeW+StrideW)'(div_coord[a]) * (SizeW+StrideW)'(dstride_q[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= div_vld;
      sum_vld_q <= mul_vld_q;
      res_vld_q <= sum_vld_q;
    end
  end

  // Adder tree and output register.
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < Slots; a++) prod_q[a] <= prod_full[a][IdxW-1:0];
    mul_oor_q  <= div_oor;
    mul_elem_q <= div_elem;
    s01_q      <= prod_q[0] + prod_q[1];
    s23_q      <= prod_q[2] + prod_q[3];
    sum_oor_q  <= mul_oor_q;
    sum_elem_q <= mul_elem_q;
    dst_q      <= sum_oor_q ? '0 : (s01_q + s23_q);
    res_oor_q  <= sum_oor_q;
    res_elem_q <= sum_elem_q;
  end

  assign result_valid_o = res_vld_q;
  assign dst_index_o    = dst_q;
  assign out_of_range_o = res_oor_q;
  assign element_out_o  = ttim_pkg::ElemPortW'(res_elem_q);

`ifndef SYNTHESIS
  // Every result answers an earlier accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, Lat))
    else $error("result without a matching accepted item");

  // An out-of-range result carries a zero destination index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_of_range_o) |-> (dst_index_o == '0))
    else $error("out-of-range result with nonzero index");

  // The element arrives unchanged with its own item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (element_out_o == ttim_pkg::ElemPortW'($past(element_i[ELEMENT_BITS-1:0], Lat))))
    else $error("element corrupted in flight");
`endif

endmodule
`default_nettype wire
